[sv/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic enq;
    logic deq;
  } spq_ctl_t;

  // What one cell shows its neighbors
  typedef struct packed {
    logic signed [VAL_W-1:0] val;
    logic                    valid;
    logic                    ge;     // valid and holds a value >= incoming one
  } spq_link_t;

endpackage

[sv/sorted_priority_queue_top.sv]
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// Bounded priority queue of signed values, largest first, ties in arrival order.
// ----------------------------------------------------------------------------
// The queue accepts one operation per clock cycle while in_stall is low and
// returns each result through an output register; a skid stage lets it take
// one more operation while a result waits, after which in_stall rises until
// the consumer drains. Entries sit in a row of DEPTH cells kept sorted from
// largest to smallest: each cell compares its entry with the incoming value
// and in the same cycle keeps it, takes the new value, or shifts from a
// neighbor, so all cells update together at any depth. An enqueue to a full
// queue is dropped with status 1, a dequeue on an empty queue returns zero
// with status 2, and every result carries the count.
module sorted_priority_queue_top #(
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             op,
  input  logic signed [spq_pkg::VAL_W-1:0] value_in,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [spq_pkg::VAL_W-1:0] value_out,
  output logic [spq_pkg::STATUS_W-1:0]     status,
  output logic [$clog2(DEPTH + 1)-1:0]     count
);
  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int RW = VAL_W + STATUS_W + CW;

  spq_link_t                links [DEPTH];
  spq_link_t                head_prev;
  spq_link_t                tail_next;
  spq_ctl_t                 ctl;
  logic                     accept;
  logic                     full;
  logic                     empty;
  logic                     buf_full;
  logic [CW-1:0]            held;
  logic [CW-1:0]            held_next;
  logic signed [VAL_W-1:0]  res_val;
  logic [STATUS_W-1:0]      res_status;
  logic [RW-1:0]            res_data;

  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;
  assign full     = links[DEPTH-1].valid;
  assign empty    = !links[0].valid;

  assign ctl.enq = accept && (op == OP_ENQ) && !full;
  assign ctl.deq = accept && (op == OP_DEQ) && !empty;

  // Ends of the chain: the head always outranks, past the tail nothing is held
  assign head_prev = '{val: '0, valid: 1'b1, ge: 1'b1};
  assign tail_next = '{val: '0, valid: 1'b0, ge: 1'b0};

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      spq_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .ctl     (ctl),
        .new_val (value_in),
        .prev    ((i == 0) ? head_prev : links[(i == 0) ? 0 : i-1]),
        .next    ((i == DEPTH-1) ? tail_next : links[(i == DEPTH-1) ? i : i+1]),
        .self    (links[i])
      );
    end
  endgenerate

  always_comb begin
    held_next  = held;
    res_val    = '0;
    res_status = ST_OK;
    if (op == OP_ENQ) begin
      if (full) begin
        res_status = ST_FULL;
      end else begin
        held_next = held + 1'b1;
      end
    end else begin
      if (empty) begin
        res_status = ST_EMPTY;
      end else begin
        res_val   = links[0].val;
        held_next = held - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (accept) begin
      held <= held_next;
    end
  end

  assign res_data = {res_val, res_status, held_next};

  spq_out_buf #(
    .W (RW)
  ) u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (res_data),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  ({value_out, status, count})
  );

endmodule

[sv/spq_cell.sv]
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: keeps, takes the new value, or shifts.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  spq_pkg::spq_ctl_t               ctl,
  input  logic signed [spq_pkg::VAL_W-1:0] new_val,
  input  spq_pkg::spq_link_t              prev,
  input  spq_pkg::spq_link_t              next,
  output spq_pkg::spq_link_t              self
);
  import spq_pkg::*;

  logic signed [VAL_W-1:0] val;
  logic                    valid;

  assign self.val   = val;
  assign self.valid = valid;
  assign self.ge    = valid && (val >= new_val);

  always_ff @(posedge clk) begin
    if (ctl.enq) begin
      if (!self.ge) begin
        // insert here if the left neighbor outranks the new value, else shift right
        if (prev.ge) begin
          val <= new_val;
        end else begin
          val <= prev.val;
        end
      end
    end else if (ctl.deq) begin
      val <= next.val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.enq) begin
      if (!self.ge) begin
        valid <= prev.ge ? 1'b1 : prev.valid;
      end
    end else if (ctl.deq) begin
      valid <= next.valid;
    end
  end

endmodule

[sv/spq_out_buf.sv]
// ----------------------------------------------------------------------------
// spq_out_buf
// Output register with a skid stage behind it.
// ----------------------------------------------------------------------------
module spq_out_buf #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [W-1:0] out_data
);

  logic [W-1:0] skid;
  logic         skid_valid;
  logic         take;

  assign take = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      if (out_valid) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (skid_valid) begin
        out_data <= skid;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      if (out_valid) begin
        skid <= push_data;
      end else begin
        out_data <= push_data;
      end
    end
  end

endmodule

[tb/tb_sorted_priority_queue_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue_top
// Self-checking testbench for the sorted priority queue.
// ----------------------------------------------------------------------------
// Drives enqueue and dequeue operations through the valid/stall input channel
// and tracks the queue contents in a sorted list to predict value, status and
// count of every result. Covers empty and full corners, signed extremes and
// ties, then runs random bursts that favour filling, draining or neither, with random
// idle gaps on both sides and one long receiver hold-off that backs up input.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue_top;
  import spq_pkg::*;

  localparam int DEPTH     = 16;
  localparam int CW        = $clog2(DEPTH + 1);
  localparam int RAND_OPS  = 1830;
  localparam int HOLD_AT   = 700;
  localparam int HOLD_CYC  = 400;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic [STATUS_W-1:0]     status;
    logic [CW-1:0]           cnt;
  } queue_result_t;

  class queue_scoreboard;
    logic signed [VAL_W-1:0] ranked_values[$];
    queue_result_t           pending_results[$];
    int                      errors;

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%t ERROR: %s", $realtime, msg);
    endfunction

    // Apply one operation to the sorted list and queue its result
    function void note_transfer(logic kind, logic signed [VAL_W-1:0] v);
      queue_result_t r;
      int            pos;
      r.value  = '0;
      r.status = ST_OK;
      if (kind == OP_ENQ) begin
        if (ranked_values.size() == DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // place behind every entry >= v
          pos = ranked_values.size();
          while (pos > 0 && ranked_values[pos-1] < v) pos--;
          ranked_values.insert(pos, v);
        end
      end else begin
        if (ranked_values.size() == 0) r.status = ST_EMPTY;
        else r.value = ranked_values.pop_front();
      end
      r.cnt = CW'(ranked_values.size());
      pending_results.push_back(r);
    endfunction

    function void check_transfer(logic signed [VAL_W-1:0] v, logic [STATUS_W-1:0] s,
                                 logic [CW-1:0] c);
      queue_result_t r;
      if (pending_results.size() == 0) begin
        flag($sformatf("result with none pending: value %0d status %0d count %0d", v, s, c));
        return;
      end
      r = pending_results.pop_front();
      if (v !== r.value || s !== r.status || c !== r.cnt)
        flag($sformatf("exp value %0d status %0d count %0d, got value %0d status %0d count %0d",
                       r.value, r.status, r.cnt, v, s, c));
    endfunction
  endclass

  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    in_valid  = 1'b0;
  logic                    op        = OP_ENQ;
  logic signed [VAL_W-1:0] value_in  = '0;
  logic                    out_stall = 1'b0;
  logic                    in_stall;
  logic                    out_valid;
  logic signed [VAL_W-1:0] value_out;
  logic [STATUS_W-1:0]     status;
  logic [CW-1:0]           count;

  queue_scoreboard board = new();
  int              items_sent;
  bit              steady;

  always #6 clk = ~clk;

  sorted_priority_queue_top #(.DEPTH(DEPTH)) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .op       (op),
    .value_in (value_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .value_out(value_out),
    .status   (status),
    .count    (count)
  );

  // Mostly no gap, some short ones, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $signed($urandom_range(0, 6)) - 3;
    if (r < 50) begin
      case ($urandom_range(0, 5))
        0: return 32'sh7FFF_FFFF;
        1: return 32'sh8000_0000;
        2: return 32'sh7FFF_FFFE;
        3: return 32'sh8000_0001;
        4: return -1;
        default: return 0;
      endcase
    end
    return $urandom;
  endfunction

  task automatic offer(input logic kind, input logic signed [VAL_W-1:0] v);
    int gap;
    in_valid <= 1'b1;
    op       <= kind;
    value_in <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_transfer(kind, v);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Result side: check transfers, stall at random, hold off once for a long stretch
  initial begin
    int  stall_left;
    bit  held_off;
    stall_left = 0;
    held_off   = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) board.check_transfer(value_out, status, count);
      if (!held_off && items_sent >= HOLD_AT) begin
        held_off = 1;
        out_stall <= 1'b1;
        repeat (HOLD_CYC) @(posedge clk);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall  <= 1'b0;
        stall_left = pick_gap();
      end
    end
  end

  initial begin
    logic signed [VAL_W-1:0] fill_vals[16];
    int                      enq_pct;
    int                      burst;
    int                      n;
    fill_vals = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, -1, 1, 5, 5, -5, 5,
                  32'sh7FFF_FFFF, 32'sh8000_0000, 0, 100, -100, 2, 3};
    items_sent = 0;
    steady     = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty dequeue, fill with extremes and ties, overflow, partial drain
    offer(OP_DEQ, $urandom);
    foreach (fill_vals[i]) offer(OP_ENQ, fill_vals[i]);
    offer(OP_ENQ, 42);
    repeat (3) offer(OP_DEQ, $urandom);
    offer(OP_ENQ, 7);

    n     = 0;
    burst = 0;
    while (n < RAND_OPS) begin
      case ($urandom_range(0, 2))
        0: enq_pct = 80;
        1: enq_pct = 50;
        default: enq_pct = 20;
      endcase
      steady = (burst % 7 == 3);
      repeat ($urandom_range(4, 40)) begin
        if ($urandom_range(0, 99) < enq_pct) offer(OP_ENQ, pick_value());
        else offer(OP_DEQ, $urandom);
        n++;
      end
      burst++;
    end
    in_valid <= 1'b0;
    steady = 0;

    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.errors == 0 && board.pending_results.size() == 0) begin
      $display("** sorted_priority_queue_top: PASSED **");
    end else begin
      $display("** sorted_priority_queue_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("** sorted_priority_queue_top: FAILED **");
    $finish;
  end

endmodule
